>>> src/shd_pkg.sv
// ----------------------------------------------------------------------------
// shd_pkg: shared types and constants of the swing hit detector
// Sizes of the sample window, downswing and intensity, and the queue word.
// ----------------------------------------------------------------------------
package shd_pkg;

  localparam int NUM_CONTROLLERS = 2;
  localparam int SAMPLE_BITS     = 16;
  localparam int CTRL_W          = 1;

  localparam int WIN_LEN  = 6;
  localparam int DOWN_LEN = 4;

  // Sum of four samples plus negation needs three more bits, signed.
  localparam int DOWN_W = SAMPLE_BITS + 3;
  // Positive downswing and peak, unsigned.
  localparam int PEAK_W = SAMPLE_BITS + 2;

  localparam int FRAC_BITS = 16;
  localparam int INTEN_W   = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(INTEN_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CTRL_W-1:0] ctrl;
    logic              pos;   // downswing above zero
    logic [PEAK_W-1:0] down;
    logic [PEAK_W-1:0] peak;
  } shd_job_t;

endpackage

>>> src/shd_sample_if.sv
// ----------------------------------------------------------------------------
// shd_sample_if: input channel of the swing hit detector
// One acceleration sample per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface shd_sample_if;
  import shd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CTRL_W-1:0]             controller;
  logic                          accel_valid;
  logic signed [SAMPLE_BITS-1:0] z_sample;

  modport source (output valid, output controller, output accel_valid, output z_sample,
                  input ready);
  modport sink   (input valid, input controller, input accel_valid, input z_sample,
                  output ready);
endinterface

>>> src/shd_hit_if.sv
// ----------------------------------------------------------------------------
// shd_hit_if: result channel of the swing hit detector
// One hit report per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface shd_hit_if;
  import shd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CTRL_W-1:0]  hit_controller;
  logic [INTEN_W-1:0] intensity;

  modport source (output valid, output hit_controller, output intensity, input ready);
  modport sink   (input valid, input hit_controller, input intensity, output ready);
endinterface

>>> src/shd_front.sv
// ----------------------------------------------------------------------------
// shd_front: sample window, hit detection and peak tracking
// Takes one sample word per cycle while the job queue has room, and queues a divide job for every hit.
// ----------------------------------------------------------------------------
module shd_front (
  input  logic           clk,
  input  logic           rst,
  shd_sample_if.sink     sample,
  output logic           job_valid,
  output shd_pkg::shd_job_t job,
  input  logic           job_ready
);
  import shd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] window [NUM_CONTROLLERS][WIN_LEN];
  logic        [PEAK_W-1:0]      peak   [NUM_CONTROLLERS];

  logic                     take;
  logic                     in_range;
  logic signed [DOWN_W-1:0] sum;
  logic signed [DOWN_W-1:0] down;
  logic                     pos;
  logic                     hit;
  logic [PEAK_W-1:0]        peak_next;

  assign sample.ready = job_ready;
  assign in_range     = ({1'b0, sample.controller} < (CTRL_W + 1)'(NUM_CONTROLLERS));
  assign take         = sample.valid && sample.ready && sample.accel_valid && in_range;

  always_comb begin
    sum = '0;
    for (int i = 0; i < DOWN_LEN; i++) begin
      sum = sum + DOWN_W'(window[sample.controller][i]);
    end
    down = -sum;
    pos  = !down[DOWN_W-1] && (down != '0);
  end

  // Window after the shift: entries 1..5 then the new sample.
  always_comb begin
    hit = (sample.z_sample > 0) && (window[sample.controller][WIN_LEN-1] > 0);
    for (int i = 1; i <= DOWN_LEN; i++) begin
      hit = hit && window[sample.controller][i][SAMPLE_BITS-1];
    end
  end

  always_comb begin
    peak_next = peak[sample.controller];
    if (pos && (PEAK_W'(down) > peak[sample.controller])) begin
      peak_next = PEAK_W'(down);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CONTROLLERS; c++) begin
        peak[c] <= '0;
        for (int i = 0; i < WIN_LEN; i++) begin
          window[c][i] <= '0;
        end
      end
    end else if (take) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window[sample.controller][i] <= window[sample.controller][i+1];
      end
      window[sample.controller][WIN_LEN-1] <= sample.z_sample;
      if (hit) begin
        peak[sample.controller] <= peak_next;
      end
    end
  end

  assign job_valid = take && hit;
  assign job.ctrl  = sample.controller;
  assign job.pos   = pos;
  assign job.down  = PEAK_W'(down);
  assign job.peak  = peak_next;

  // A positive downswing never exceeds the peak handed to the divider.
  a_peak_covers_down: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.pos |-> job.peak >= job.down && job.peak != '0)
    else $error("queued peak below downswing");

  // Peak only moves on a hit word.
  a_peak_on_hit_only: assert property (@(posedge clk) disable iff (rst)
    !(take && hit) |=> peak[0] == $past(peak[0]))
    else $error("peak changed without a hit");

  a_job_needs_space: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_ready)
    else $error("job raised while queue full");

endmodule

>>> src/shd_queue.sv
// ----------------------------------------------------------------------------
// shd_queue: short job queue between front and divider
// Register file queue; each side stalls on its own.
// ----------------------------------------------------------------------------
module shd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  shd_pkg::shd_job_t push_job,
  output logic              push_ready,
  output logic              pop_valid,
  output shd_pkg::shd_job_t pop_job,
  input  logic              pop_ready
);
  import shd_pkg::*;

  shd_job_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

>>> src/shd_divider.sv
// ----------------------------------------------------------------------------
// shd_divider: intensity divider and result register
// Restoring division of downswing * 2^16 by peak, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module shd_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  shd_pkg::shd_job_t job,
  output logic              job_ready,
  shd_hit_if.source         hit
);
  import shd_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [PEAK_W-1:0]  rem;
  logic [PEAK_W-1:0]  divisor;
  logic [INTEN_W-1:0] shreg;
  logic [INTEN_W-1:0] quo;
  logic [CTRL_W-1:0]  ctrl;

  logic [PEAK_W:0]    trial;
  logic [PEAK_W:0]    diff;
  logic               fits;

  assign job_ready = (state == IDLE);

  // Bring the next dividend bit in and try to subtract.
  assign trial = {rem, shreg[INTEN_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      hit.valid <= 1'b0;
    end else begin
      // Drop a taken word; in FINISH the arm below decides valid.
      if (hit.valid && hit.ready && (state != FINISH)) begin
        hit.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            ctrl    <= job.ctrl;
            divisor <= job.peak;
            count   <= '0;
            quo     <= '0;
            // High part of the dividend is down >> 1; down[0] then zeros follow.
            rem     <= job.down >> 1;
            shreg   <= {job.down[0], {(INTEN_W-1){1'b0}}};
            state   <= job.pos ? RUN : FINISH;
          end
        end
        RUN: begin
          rem   <= fits ? diff[PEAK_W-1:0] : rem << 1 | PEAK_W'(shreg[INTEN_W-1]);
          quo   <= {quo[INTEN_W-2:0], fits};
          shreg <= shreg << 1;
          count <= count + 1'b1;
          if (count == CNT_W'(INTEN_W - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!hit.valid || hit.ready) begin
            hit.valid          <= 1'b1;
            hit.hit_controller <= ctrl;
            hit.intensity      <= quo;
            state              <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    hit.valid |-> hit.intensity <= INTEN_W'(1 << FRAC_BITS))
    else $error("intensity above full strength");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == RUN |-> rem < divisor)
    else $error("partial remainder not below peak");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    $rose(state == FINISH) && $past(state) == RUN |-> $past(count) == CNT_W'(INTEN_W - 1))
    else $error("division left early");

endmodule

>>> src/swing_hit_detector.sv
// ----------------------------------------------------------------------------
// swing_hit_detector: per-controller swing hit detection with intensity
// Windowed downswing detector feeding an iterative intensity divider.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               handshake
//  sample   in   controller, accel_valid, z_sample     valid / ready
//  hit      out  hit_controller, intensity (Q1.16)     valid / ready
//
//  The front takes one sample word a cycle while the job queue has room.
//  In the divider a hit takes a load, 17 quotient bits and a write-out;
//  the bit-serial divider sets the sustained rate for back-to-back hits.
//  Synchronous reset clears windows, peaks, queue and the result valid bit.
//  A stalled result holds; the front and queue keep working behind it until the queue is full.
// ----------------------------------------------------------------------------
module swing_hit_detector (
  input  logic       clk,
  input  logic       rst,
  shd_sample_if.sink sample,
  shd_hit_if.source  hit
);
  import shd_pkg::*;

  logic     fq_valid;
  logic     fq_ready;
  shd_job_t fq_job;
  logic     qd_valid;
  logic     qd_ready;
  shd_job_t qd_job;

  shd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .job_valid (fq_valid),
    .job       (fq_job),
    .job_ready (fq_ready)
  );

  shd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_job   (fq_job),
    .push_ready (fq_ready),
    .pop_valid  (qd_valid),
    .pop_job    (qd_job),
    .pop_ready  (qd_ready)
  );

  shd_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qd_valid),
    .job       (qd_job),
    .job_ready (qd_ready),
    .hit       (hit)
  );

endmodule
